FILE: src/ncia_pkg.sv
// Shared constants and input codes for the nearest corner id assignment block.
package ncia_pkg;

    localparam int COORD_W = 16;
    localparam int ID_W = 31;
    localparam int RADIUS_W = 12;
    localparam int KIND_W = 2;
    localparam int THR_W = 2 * RADIUS_W;
    localparam int SQ_W = 2 * COORD_W;
    localparam int DIST_W = SQ_W + 1;
    localparam int MAX_CORNERS_DEF = 256;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(80);

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

endpackage

FILE: src/ncia_ram.sv
// Generic single write port, single read port RAM with registered read data.
module ncia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/nearest_corner_id_assign_core.sv
// Top level of the nearest corner id assignment block: corner store and query scan.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  input   | start, busy          | kind, pos_x, pos_y, corner_id
//  result  | done (one cycle)     | matched, match_id, overflow
//  config  | cfg_wr_en            | cfg_wr_data (match radius)
//
// Clear and load leave busy low.
// A query keeps busy high while its scan runs, also when the set is empty; the single distance
// unit reads one stored corner per cycle from the corner RAM and squares it in a three stage
// pipeline; the result follows on done in the next cycle.
// Reset clears the count, the overflow flag and the sequencer; the RAM is not cleared.
// The receiver cannot stall: each result is shown on done for exactly one cycle.
module nearest_corner_id_assign_core #(
    parameter int MAX_CORNERS = ncia_pkg::MAX_CORNERS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ncia_pkg::KIND_W-1:0]    kind,
    input  logic [ncia_pkg::COORD_W-1:0]   pos_x,
    input  logic [ncia_pkg::COORD_W-1:0]   pos_y,
    input  logic [ncia_pkg::ID_W-1:0]      corner_id,
    input  logic                           cfg_wr_en,
    input  logic [ncia_pkg::RADIUS_W-1:0]  cfg_wr_data,
    output logic                           done,
    output logic                           matched,
    output logic [ncia_pkg::ID_W-1:0]      match_id,
    output logic                           overflow
);

    import ncia_pkg::*;

    localparam int AW = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int CW = $clog2(MAX_CORNERS + 1);
    localparam int ENTRY_W = 2 * COORD_W + ID_W;
    localparam logic [CW-1:0] COUNT_FULL = CW'(MAX_CORNERS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                state_reg, state_next;
    logic [RADIUS_W-1:0] radius_reg;
    logic [CW-1:0]       count_reg;
    logic                dropped_reg;
    logic [CW-1:0]       issue_reg;
    logic [COORD_W-1:0]  qx_reg, qy_reg;
    logic                v1_reg, v2_reg, v3_reg;
    logic [COORD_W-1:0]  dx_reg, dy_reg;
    logic [ID_W-1:0]     id2_reg, id3_reg;
    logic [SQ_W-1:0]     dx2_reg, dy2_reg;
    logic [THR_W-1:0]    best_reg;
    logic [ID_W-1:0]     best_id_reg;
    logic                found_reg;
    logic                done_reg;
    logic                matched_reg;
    logic [ID_W-1:0]     match_id_reg;
    logic                overflow_reg;

    logic               accept;
    logic               full;
    logic               ram_we;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [COORD_W-1:0] rd_x, rd_y;
    logic [ID_W-1:0]    rd_id;
    logic [DIST_W-1:0]  sq_dist;
    logic               closer;
    logic               scan_end;

    assign accept = start && (state_reg == ST_IDLE);
    assign full = (count_reg == COUNT_FULL);
    assign ram_we = accept && (kind == KIND_LOAD) && !full;
    assign ram_wdata = {pos_x, pos_y, corner_id};
    assign ram_re = (state_reg == ST_SCAN) && (issue_reg != count_reg);
    assign {rd_x, rd_y, rd_id} = ram_rdata;
    assign sq_dist = DIST_W'(dx2_reg) + DIST_W'(dy2_reg);
    assign closer = v3_reg && (sq_dist < DIST_W'(best_reg));
    assign scan_end = (state_reg == ST_SCAN) && !ram_re && !v1_reg && !v2_reg && !v3_reg;

    ncia_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CORNERS),
        .ADDR_W(AW)
    ) u_corner_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(issue_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            radius_reg <= RADIUS_RESET;
            count_reg <= '0;
            dropped_reg <= 1'b0;
            issue_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            found_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= scan_end;
            v1_reg <= ram_re;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            if (accept && (kind == KIND_CLEAR))
            begin
                count_reg <= '0;
                dropped_reg <= 1'b0;
            end
            if (accept && (kind == KIND_LOAD))
            begin
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (accept && (kind == KIND_QUERY))
            begin
                issue_reg <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (ram_re)
                begin
                    issue_reg <= issue_reg + CW'(1);
                end
                if (closer)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (kind == KIND_QUERY))
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
            best_reg <= THR_W'(radius_reg) * THR_W'(radius_reg);
        end
        else if (closer)
        begin
            best_reg <= sq_dist[THR_W-1:0];
            best_id_reg <= id3_reg;
        end
        dx_reg <= (rd_x >= qx_reg) ? (rd_x - qx_reg) : (qx_reg - rd_x);
        dy_reg <= (rd_y >= qy_reg) ? (rd_y - qy_reg) : (qy_reg - rd_y);
        id2_reg <= rd_id;
        dx2_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        dy2_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        id3_reg <= id2_reg;
        if (scan_end)
        begin
            matched_reg <= found_reg;
            match_id_reg <= found_reg ? best_id_reg : '0;
            overflow_reg <= dropped_reg;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign matched = matched_reg;
    assign match_id = match_id_reg;
    assign overflow = overflow_reg;

endmodule

FILE: src/ncia_check.sv
// Port-level checker for the nearest corner id assignment block, with its bind.
module ncia_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [ncia_pkg::KIND_W-1:0]   kind,
    input logic                          done,
    input logic                          matched,
    input logic [ncia_pkg::ID_W-1:0]     match_id
);

    import ncia_pkg::*;

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_QUERY)) |=> busy)
        else $error("query transfer did not make the block busy");

    a_other_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind != KIND_QUERY)) |=> (!busy && !done))
        else $error("clear or load transfer caused busy or a result");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result transfer not at the end of a query");

    a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !matched) |-> (match_id == '0))
        else $error("unmatched result carries a nonzero id");

endmodule

bind nearest_corner_id_assign_core ncia_check u_ncia_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .kind    (kind),
    .done    (done),
    .matched (matched),
    .match_id(match_id)
);
